FILE: design/fcpr_pkg.sv
// ----------------------------------------------------------------------------
// fcpr_pkg
// Shared types and constants of the framed command packet receiver.
// ----------------------------------------------------------------------------
package fcpr_pkg;

    localparam int FCPR_IN_DEPTH  = 4;
    localparam int FCPR_OUT_DEPTH = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN = 2'd2;

    localparam logic        ENABLE_RESET  = 1'b0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] MAX_LEN_RESET = 16'd2048;

    localparam logic [7:0] HDR0_BYTE = 8'h02;
    localparam logic [7:0] HDR1_BYTE = 8'hFD;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_PACKET  = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
    localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  packet_type;
        logic [15:0] command_code;
        logic [15:0] error_code_field;
        logic [15:0] payload_length;
        logic [1:0]  packet_status;
    } result_t;

endpackage

FILE: design/fcpr_fifo.sv
// ----------------------------------------------------------------------------
// fcpr_fifo
// Small register queue; decouples the receive side, the parser and the sink.
// ----------------------------------------------------------------------------
module fcpr_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: design/fcpr_parser.sv
// ----------------------------------------------------------------------------
// fcpr_parser
// Frame parser: configuration registers, header hunt, field capture, length limit, checksum and idle timeout.
// ----------------------------------------------------------------------------
module fcpr_parser
    import fcpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_write_t cfg,
    input  logic       item_valid,
    input  item_t      item,
    output logic       item_take,
    input  logic       res_full,
    output logic       res_push,
    output result_t    res
);

    typedef enum logic [3:0] {
        PH_HDR0  = 4'd0,
        PH_HDR1  = 4'd1,
        PH_TYPE  = 4'd2,
        PH_CMD_L = 4'd3,
        PH_CMD_H = 4'd4,
        PH_ERR_L = 4'd5,
        PH_ERR_H = 4'd6,
        PH_LEN_L = 4'd7,
        PH_LEN_H = 4'd8,
        PH_DATA  = 4'd9,
        PH_SUM   = 4'd10
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic        enable_reg, enable_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [15:0] max_len_reg, max_len_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [15:0] err_reg, err_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] idle_reg, idle_next;
    logic [15:0] pos_inc;
    logic [7:0]  b;
    logic [7:0]  sum_add;
    logic        emit;
    logic        emit_kind;
    logic [1:0]  emit_status;

    assign item_take = item_valid && !res_full;
    assign b         = item.rx_byte;
    assign sum_add   = sum_reg + b;
    assign pos_inc   = pos_reg + 1'b1;

    always_comb
    begin
        enable_next  = enable_reg;
        timeout_next = timeout_reg;
        max_len_next = max_len_reg;
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        type_next    = type_reg;
        cmd_next     = cmd_reg;
        err_next     = err_reg;
        len_next     = len_reg;
        pos_next     = pos_reg;
        idle_next    = idle_reg;
        phase_eff    = phase_reg;
        emit         = 1'b0;
        emit_kind    = KIND_PAYLOAD;
        emit_status  = STATUS_OK;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ENABLE:
                begin
                    if (cfg.data[0] && !enable_reg)
                    begin
                        phase_next = PH_HDR0;
                        idle_next  = '0;
                    end
                    enable_next = cfg.data[0];
                end
                REG_TIMEOUT: timeout_next = cfg.data;
                REG_MAX_LEN: max_len_next = cfg.data;
                default: ;
            endcase
        end

        if (item_take)
        begin
            if (item.opcode == OP_TICK)
            begin
                if (idle_reg != 16'hFFFF)
                begin
                    idle_next = idle_reg + 1'b1;
                end
            end
            else if (enable_reg)
            begin
                // a long gap forces a fresh header hunt
                phase_eff = (idle_reg >= timeout_reg) ? PH_HDR0 : phase_reg;
                idle_next = '0;
                unique case (phase_eff)
                    PH_HDR1:
                    begin
                        if (b == HDR1_BYTE)
                        begin
                            sum_next   = sum_add;
                            phase_next = PH_TYPE;
                        end
                        else
                        begin
                            phase_next = PH_HDR0;
                        end
                    end
                    PH_TYPE:
                    begin
                        type_next  = b;
                        sum_next   = sum_add;
                        phase_next = PH_CMD_L;
                    end
                    PH_CMD_L:
                    begin
                        cmd_next   = {8'h00, b};
                        sum_next   = sum_add;
                        phase_next = PH_CMD_H;
                    end
                    PH_CMD_H:
                    begin
                        cmd_next   = {b, cmd_reg[7:0]};
                        sum_next   = sum_add;
                        phase_next = PH_ERR_L;
                    end
                    PH_ERR_L:
                    begin
                        err_next   = {8'h00, b};
                        sum_next   = sum_add;
                        phase_next = PH_ERR_H;
                    end
                    PH_ERR_H:
                    begin
                        err_next   = {b, err_reg[7:0]};
                        sum_next   = sum_add;
                        phase_next = PH_LEN_L;
                    end
                    PH_LEN_L:
                    begin
                        len_next   = {8'h00, b};
                        sum_next   = sum_add;
                        phase_next = PH_LEN_H;
                    end
                    PH_LEN_H:
                    begin
                        len_next = {b, len_reg[7:0]};
                        sum_next = sum_add;
                        if ({b, len_reg[7:0]} == 16'h0000)
                        begin
                            phase_next = PH_SUM;
                        end
                        else if ({b, len_reg[7:0]} <= max_len_reg)
                        begin
                            pos_next   = '0;
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            phase_next  = PH_HDR0;
                            emit        = 1'b1;
                            emit_kind   = KIND_PACKET;
                            emit_status = STATUS_TOO_BIG;
                        end
                    end
                    PH_DATA:
                    begin
                        sum_next  = sum_add;
                        emit      = 1'b1;
                        emit_kind = KIND_PAYLOAD;
                        pos_next  = pos_inc;
                        if (pos_inc == len_reg)
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        // sum plus checksum byte wraps to zero when intact
                        phase_next  = PH_HDR0;
                        emit        = 1'b1;
                        emit_kind   = KIND_PACKET;
                        emit_status = (sum_add == 8'h00) ? STATUS_OK : STATUS_BAD_SUM;
                    end
                    default:
                    begin
                        phase_next = PH_HDR0;
                        if (b == HDR0_BYTE)
                        begin
                            sum_next   = b;
                            phase_next = PH_HDR1;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_push             = emit;
        res.result_kind      = emit_kind;
        res.payload_byte     = (emit_kind == KIND_PAYLOAD) ? b : 8'h00;
        res.payload_index    = (emit_kind == KIND_PAYLOAD) ? pos_reg : 16'h0000;
        res.packet_type      = type_next;
        res.command_code     = cmd_next;
        res.error_code_field = err_next;
        res.payload_length   = len_next;
        res.packet_status    = emit_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= ENABLE_RESET;
            timeout_reg <= TIMEOUT_RESET;
            max_len_reg <= MAX_LEN_RESET;
            phase_reg   <= PH_HDR0;
            sum_reg     <= '0;
            type_reg    <= '0;
            cmd_reg     <= '0;
            err_reg     <= '0;
            len_reg     <= '0;
            pos_reg     <= '0;
            idle_reg    <= '0;
        end
        else
        begin
            enable_reg  <= enable_next;
            timeout_reg <= timeout_next;
            max_len_reg <= max_len_next;
            phase_reg   <= phase_next;
            sum_reg     <= sum_next;
            type_reg    <= type_next;
            cmd_reg     <= cmd_next;
            err_reg     <= err_next;
            len_reg     <= len_next;
            pos_reg     <= pos_next;
            idle_reg    <= idle_next;
        end
    end

    // a result never meets a full result queue
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result pushed into full queue");

    // inside the payload the position stays below the nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (len_reg != 16'h0000) && (pos_reg < len_reg))
        else $error("payload position out of range");

    // payload results always carry ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.result_kind == KIND_PAYLOAD) |-> (res.packet_status == STATUS_OK))
        else $error("payload result with error status");

    // length error only for a length above the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.packet_status == STATUS_TOO_BIG)
            |-> (res.payload_length > max_len_reg) && (res.result_kind == KIND_PACKET))
        else $error("length error without oversize length");

endmodule

FILE: design/framed_command_packet_receiver.sv
// ----------------------------------------------------------------------------
// framed_command_packet_receiver
// A request is registered in the input queue, and its result in the result queue that drives the result ports.
// Throughput: one request per cycle; the parser takes one request from the
// input queue each cycle while the result queue has room.
// Reset: asynchronous, active low; queues empty, parser hunts for the header,
// receive disabled, timeout 100 ticks, maximum payload 2048 bytes.
// ----------------------------------------------------------------------------
module framed_command_packet_receiver
    import fcpr_pkg::*;
#(
    parameter int IN_DEPTH  = FCPR_IN_DEPTH,
    parameter int OUT_DEPTH = FCPR_OUT_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   opcode,
    input  logic [7:0]             rx_byte,
    output logic                   empty,
    input  logic                   pop,
    output logic                   result_kind,
    output logic [7:0]             payload_byte,
    output logic [15:0]            payload_index,
    output logic [7:0]             packet_type,
    output logic [15:0]            command_code,
    output logic [15:0]            error_code_field,
    output logic [15:0]            payload_length,
    output logic [1:0]             packet_status,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    item_t      in_item;
    item_t      q_item;
    logic       q_empty;
    logic       q_take;
    cfg_write_t cfg;
    logic       res_push;
    logic       res_full;
    result_t    res_in;
    result_t    res_out;

    assign in_item.opcode  = opcode;
    assign in_item.rx_byte = rx_byte;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    fcpr_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (IN_DEPTH)
    ) u_in_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (in_item),
        .full  (full),
        .pop   (q_take),
        .dout  (q_item),
        .empty (q_empty)
    );

    fcpr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (!q_empty),
        .item       (q_item),
        .item_take  (q_take),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    fcpr_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_out),
        .empty (empty)
    );

    assign result_kind      = res_out.result_kind;
    assign payload_byte     = res_out.payload_byte;
    assign payload_index    = res_out.payload_index;
    assign packet_type      = res_out.packet_type;
    assign command_code     = res_out.command_code;
    assign error_code_field = res_out.error_code_field;
    assign payload_length   = res_out.payload_length;
    assign packet_status    = res_out.packet_status;

endmodule

FILE: sim/tb_framed_command_packet_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framed_command_packet_receiver
// Self-checking bench for the framed command packet receiver. Frames, broken
// frames, ticks and noise go in through the request queue while a scoreboard
// class tracks the parser and checks every payload byte and packet report.
// Senders and receivers idle at random, and one long receiver hold-off backs
// up both queues.
// ----------------------------------------------------------------------------
module tb_framed_command_packet_receiver;
    import fcpr_pkg::*;

    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 2 * FCPR_IN_DEPTH + 4;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic [3:0] {
        HUNT_STX, HUNT_MARK, TAKE_TYPE, CMD_LO, CMD_HI, ERR_LO, ERR_HI,
        LEN_LO, LEN_HI, TAKE_DATA, TAKE_SUM
    } stage_t;

    class frame_checker;
        logic        rx_on;
        logic [15:0] gap_limit;
        logic [15:0] len_limit;
        stage_t      stage;
        logic [7:0]  csum;
        logic [7:0]  frame_type;
        logic [15:0] frame_cmd;
        logic [15:0] frame_err;
        logic [15:0] frame_len;
        logic [15:0] next_index;
        logic [15:0] tick_count;
        result_t     expected_results[$];
        int          errors;
        int          n_bytes;
        int          n_ok;
        int          n_bad_sum;
        int          n_too_long;

        function new();
            rx_on      = ENABLE_RESET;
            gap_limit  = TIMEOUT_RESET;
            len_limit  = MAX_LEN_RESET;
            stage      = HUNT_STX;
            csum       = '0;
            frame_type = '0;
            frame_cmd  = '0;
            frame_err  = '0;
            frame_len  = '0;
            next_index = '0;
            tick_count = '0;
            errors     = 0;
            n_bytes    = 0;
            n_ok       = 0;
            n_bad_sum  = 0;
            n_too_long = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
            case (idx)
                REG_ENABLE:
                begin
                    // turning the channel on restarts the header hunt
                    if (value[0] && !rx_on)
                    begin
                        stage      = HUNT_STX;
                        tick_count = '0;
                    end
                    rx_on = value[0];
                end
                REG_TIMEOUT: gap_limit = value;
                REG_MAX_LEN: len_limit = value;
                default: ;
            endcase
        endfunction

        function result_t make_result(logic kind, logic [7:0] pbyte, logic [15:0] pindex,
                                      logic [1:0] status);
            result_t r;
            r.result_kind      = kind;
            r.payload_byte     = pbyte;
            r.payload_index    = pindex;
            r.packet_type      = frame_type;
            r.command_code     = frame_cmd;
            r.error_code_field = frame_err;
            r.payload_length   = frame_len;
            r.packet_status    = status;
            return r;
        endfunction

        function void note_request(logic op, logic [7:0] b);
            logic [7:0] want_sum;
            if (op == OP_TICK)
            begin
                if (tick_count != 16'hFFFF)
                    tick_count++;
                return;
            end
            if (!rx_on)
                return;
            if (tick_count >= gap_limit)
                stage = HUNT_STX;
            tick_count = '0;
            case (stage)
                HUNT_MARK:
                begin
                    if (b == HDR1_BYTE)
                    begin
                        csum += b;
                        stage = TAKE_TYPE;
                    end
                    else
                        stage = HUNT_STX;
                end
                TAKE_TYPE:
                begin
                    frame_type = b;
                    csum += b;
                    stage = CMD_LO;
                end
                CMD_LO:
                begin
                    frame_cmd = {8'h00, b};
                    csum += b;
                    stage = CMD_HI;
                end
                CMD_HI:
                begin
                    frame_cmd[15:8] = b;
                    csum += b;
                    stage = ERR_LO;
                end
                ERR_LO:
                begin
                    frame_err = {8'h00, b};
                    csum += b;
                    stage = ERR_HI;
                end
                ERR_HI:
                begin
                    frame_err[15:8] = b;
                    csum += b;
                    stage = LEN_LO;
                end
                LEN_LO:
                begin
                    frame_len = {8'h00, b};
                    csum += b;
                    stage = LEN_HI;
                end
                LEN_HI:
                begin
                    frame_len[15:8] = b;
                    csum += b;
                    if (frame_len == 16'd0)
                        stage = TAKE_SUM;
                    else if (frame_len <= len_limit)
                    begin
                        next_index = '0;
                        stage = TAKE_DATA;
                    end
                    else
                    begin
                        stage = HUNT_STX;
                        expected_results.push_back(
                            make_result(KIND_PACKET, 8'h00, 16'h0000, STATUS_TOO_BIG));
                    end
                end
                TAKE_DATA:
                begin
                    csum += b;
                    expected_results.push_back(make_result(KIND_PAYLOAD, b, next_index,
                                                           STATUS_OK));
                    next_index++;
                    if (next_index == frame_len)
                        stage = TAKE_SUM;
                end
                TAKE_SUM:
                begin
                    want_sum = 8'h00 - csum;
                    stage = HUNT_STX;
                    expected_results.push_back(make_result(KIND_PACKET, 8'h00, 16'h0000,
                        (want_sum == b) ? STATUS_OK : STATUS_BAD_SUM));
                end
                default:
                begin
                    stage = HUNT_STX;
                    if (b == HDR0_BYTE)
                    begin
                        csum  = b;
                        stage = HUNT_MARK;
                    end
                end
            endcase
        endfunction

        function string show(result_t r);
            return $sformatf("kind %0d byte %h index %h type %h cmd %h err %h len %h status %0d",
                             r.result_kind, r.payload_byte, r.payload_index, r.packet_type,
                             r.command_code, r.error_code_field, r.payload_length,
                             r.packet_status);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %s", show(got));
                return;
            end
            want = expected_results.pop_front();
            if (want.result_kind == KIND_PAYLOAD)
                n_bytes++;
            else
                case (want.packet_status)
                    STATUS_OK:      n_ok++;
                    STATUS_BAD_SUM: n_bad_sum++;
                    default:        n_too_long++;
                endcase
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch expected: %s", show(want));
                    $display("         actual:   %s", show(got));
                end
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   push      = 1'b0;
    logic                   opcode    = OP_BYTE;
    logic [7:0]             rx_byte   = 8'h00;
    logic                   pop       = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_ENABLE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   full;
    logic                   empty;
    logic                   cfg_ready;
    logic                   result_kind;
    logic [7:0]             payload_byte;
    logic [15:0]            payload_index;
    logic [7:0]             packet_type;
    logic [15:0]            command_code;
    logic [15:0]            error_code_field;
    logic [15:0]            payload_length;
    logic [1:0]             packet_status;

    logic hold_off     = 1'b0;
    int   gap_pct      = 0;
    int   stall_pct    = 0;
    int   tick_pct     = 0;
    int   items_sent   = 0;
    int   quiet_cycles = 0;
    int   input_stalls = 0;
    int   fails;

    frame_checker board;

    framed_command_packet_receiver u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .opcode           (opcode),
        .rx_byte          (rx_byte),
        .empty            (empty),
        .pop              (pop),
        .result_kind      (result_kind),
        .payload_byte     (payload_byte),
        .payload_index    (payload_index),
        .packet_type      (packet_type),
        .command_code     (command_code),
        .error_code_field (error_code_field),
        .payload_length   (payload_length),
        .packet_status    (packet_status),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #10 clk = ~clk;

    // result side: check on each pop, then pick the next pop level
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            board.check_result('{result_kind, payload_byte, payload_index, packet_type,
                                 command_code, error_code_field, payload_length,
                                 packet_status});
        pop <= rst_n && !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
        if (rst_n && push && full)
            input_stalls <= input_stalls + 1;
    end

    task automatic push_item(input logic op, input logic [7:0] value);
        while ($urandom_range(99) < gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        opcode  <= op;
        rx_byte <= value;
        @(posedge clk);
        while (full)
            @(posedge clk);
        board.note_request(op, value);
        items_sent++;
    endtask

    task automatic push_ticks(input int count);
        repeat (count)
            push_item(OP_TICK, 8'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every outstanding result is back and the parser has gone quiet
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (board.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic hold_results(input int cycles);
        hold_off <= 1'b1;
        repeat (cycles)
            @(posedge clk);
        hold_off <= 1'b0;
    endtask

    task automatic send_frame(input logic [7:0] ptype, input logic [15:0] cmd,
                              input logic [15:0] err, input logic [15:0] len,
                              input bit bad_sum = 0, input bit bad_mark = 0,
                              input int cut = -1, input int gap_at = -1,
                              input int gap_len = 0);
        logic [7:0] seq[$];
        logic [7:0] total;
        total = 8'h00;
        seq = '{HDR0_BYTE, HDR1_BYTE, ptype, cmd[7:0], cmd[15:8], err[7:0], err[15:8],
                len[7:0], len[15:8]};
        if (len <= board.len_limit)
        begin
            repeat (len)
                seq.push_back(8'($urandom));
            foreach (seq[k])
                total += seq[k];
            total = 8'h00 - total;
            if (bad_sum)
                total ^= 8'($urandom_range(1, 255));
            seq.push_back(total);
        end
        if (bad_mark)
            seq[1] = HDR1_BYTE ^ 8'($urandom_range(1, 255));
        while (cut >= 0 && seq.size() > cut)
            void'(seq.pop_back());
        foreach (seq[k])
        begin
            if (k == gap_at)
                push_ticks(gap_len);
            if ($urandom_range(99) < tick_pct)
                push_ticks($urandom_range(1, 6));
            push_item(OP_BYTE, seq[k]);
        end
    endtask

    task automatic run_random(input int count);
        int first;
        int len;
        int pick;
        first = items_sent;
        while (items_sent - first < count)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 80 || board.len_limit == 16'hFFFF)
                len = $urandom_range(0, 8);
            else
                len = $urandom_range(board.len_limit + 1, 65535);
            if (pick < 65)
                send_frame(8'($urandom), 16'($urandom), 16'($urandom), 16'(len));
            else if (pick < 77)
                send_frame(8'($urandom), 16'($urandom), 16'($urandom), 16'(len), 1);
            else if (pick < 85)
                send_frame(8'($urandom), 16'($urandom), 16'($urandom), 16'(len), 0, 0,
                           $urandom_range(1, len + 9));
            else if (pick < 90)
                send_frame(8'($urandom), 16'($urandom), 16'($urandom), 16'(len), 0, 1);
            else
                repeat ($urandom_range(1, 4))
                    push_item(1'($urandom), 8'($urandom));
        end
    endtask

    task automatic run_phase(input int gap, input int stall, input int count);
        gap_pct   = gap;
        stall_pct = stall;
        tick_pct  = 5;
        run_random(count);
        settle();
    endtask

    initial
    begin
        board = new();
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // channel closed: bytes dropped, ticks still counted
        write_reg(REG_TIMEOUT, 16'd4);
        write_reg(REG_MAX_LEN, 16'd3);
        push_item(OP_BYTE, HDR0_BYTE);
        push_item(OP_BYTE, HDR1_BYTE);
        push_item(OP_TICK, 8'hFF);
        settle();
        write_reg(REG_ENABLE, 16'hFFFF);

        send_frame(8'hFF, 16'hFFFF, 16'h0000, 16'd3);
        send_frame(8'h00, 16'h0000, 16'hFFFF, 16'd0, 1);
        send_frame(8'h5A, 16'h1234, 16'h8001, 16'd4);
        // second header byte wrong, the repeated start byte is not taken as a new start
        push_item(OP_BYTE, HDR0_BYTE);
        push_item(OP_BYTE, HDR0_BYTE);
        push_item(OP_BYTE, HDR1_BYTE);
        send_frame(8'hA5, 16'h00FF, 16'hFF00, 16'd2, 0, 0, -1, 3, 3);
        send_frame(8'h33, 16'h4321, 16'h0001, 16'd1, 0, 0, -1, 2, 4);
        send_frame(8'h81, 16'h8000, 16'h7FFF, 16'd2);

        // enable rewritten while already on: parsing carries on
        send_frame(8'h11, 16'h2222, 16'h3333, 16'd2, 0, 0, 5);
        settle();
        write_reg(REG_ENABLE, 16'h0001);
        send_frame(8'h44, 16'h5555, 16'h6666, 16'd1);
        send_frame(8'h77, 16'h0102, 16'h0304, 16'd1);

        // off and on again mid-frame restarts the hunt
        send_frame(8'h99, 16'hAAAA, 16'hBBBB, 16'd2, 0, 0, 4);
        settle();
        write_reg(REG_ENABLE, 16'h0000);
        push_item(OP_BYTE, HDR0_BYTE);
        push_item(OP_BYTE, 8'h00);
        settle();
        write_reg(REG_ENABLE, 16'h0001);
        send_frame(8'hCC, 16'hDDDD, 16'hEEEE, 16'd2);
        settle();

        // zero maximum rejects every nonzero length
        write_reg(REG_MAX_LEN, 16'd0);
        send_frame(8'h12, 16'h3456, 16'h789A, 16'd1);
        send_frame(8'h21, 16'h6543, 16'hA987, 16'd0);
        settle();

        // zero timeout restarts the hunt on every byte
        write_reg(REG_TIMEOUT, 16'd0);
        send_frame(8'h0F, 16'hF00F, 16'h0FF0, 16'd0);
        settle();

        // a long timeout lets a short tick gap pass without a restart
        write_reg(REG_TIMEOUT, 16'hFFFF);
        write_reg(REG_MAX_LEN, 16'd8);
        send_frame(8'h3C, 16'hC33C, 16'h5AA5, 16'd2, 0, 0, -1, 3, 5);
        send_frame(8'hC3, 16'h3CC3, 16'hA55A, 16'd1);
        settle();

        write_reg(REG_TIMEOUT, 16'($urandom_range(2, 6)));
        write_reg(REG_MAX_LEN, 16'd12);
        run_phase(0, 0, 65);

        write_reg(REG_TIMEOUT, 16'hFFFF);
        write_reg(REG_MAX_LEN, MAX_LEN_RESET);
        write_reg(REG_SPARE, 16'($urandom));
        run_phase(73, 0, 65);

        write_reg(REG_TIMEOUT, 16'd1);
        write_reg(REG_MAX_LEN, 16'($urandom_range(1, 8)));
        run_phase(0, 73, 65);

        // long receiver hold-off backs up both queues
        write_reg(REG_MAX_LEN, MAX_LEN_RESET);
        write_reg(REG_TIMEOUT, TIMEOUT_RESET);
        gap_pct   = 0;
        stall_pct = 0;
        tick_pct  = 0;
        fork
            hold_results(HOLD_CYCLES);
        join_none
        send_frame(8'hE1, 16'hBEEF, 16'h0000, 16'd40);
        settle();

        write_reg(REG_TIMEOUT, 16'($urandom_range(1, 65535)));
        write_reg(REG_MAX_LEN, 16'hFFFF);
        run_phase(33, 33, 65);

        write_reg(REG_ENABLE, 16'h0000);
        write_reg(REG_TIMEOUT, 16'd3);
        write_reg(REG_MAX_LEN, 16'd6);
        write_reg(REG_ENABLE, 16'h0001);
        run_phase(0, 0, 65);

        fails = board.errors + board.expected_results.size();
        if (board.expected_results.size() != 0)
            $display("%0d expected results never arrived", board.expected_results.size());
        $display("checked %0d payload bytes and %0d packets",
                 board.n_bytes, board.n_ok + board.n_bad_sum + board.n_too_long);
        $display("  (ok %0d, bad checksum %0d, too long %0d)",
                 board.n_ok, board.n_bad_sum, board.n_too_long);
        $display("%0d requests sent, input held off for %0d cycles under back-pressure",
                 items_sent, input_stalls);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
